>>> hw/rtl/wtlo_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wtlo_pkg
// Shared types and constants of the wave-terrain line oscillator.
// ---------------------------------------------------------------------------
package wtlo_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [15:0] COORD_LOW_RESET  = 16'd13107;
    localparam logic [15:0] COORD_HIGH_RESET = 16'd52429;

    localparam logic [31:0] PHASE_INC_RESET = 32'd42852282;
    localparam logic [8:0]  SIZE_RESET      = 9'd256;
    localparam logic [15:0] RAMP_RESET      = 16'd1000;

    // register indexes
    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;
    localparam logic [1:0] REG_RAMP      = 2'd3;

    // action codes
    localparam logic [1:0] ACT_PIXEL  = 2'd0;
    localparam logic [1:0] ACT_LINE   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // one classified item in the queue
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  bright;
        logic [63:0] targets;   // x1,y1,x2,y2 from low bits
    } wtlo_cmd_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [31:0] phase_inc;
        logic [8:0]  width;
        logic [8:0]  height;
        logic [15:0] ramp;
    } wtlo_cfg_t;

endpackage : wtlo_pkg
`default_nettype wire

>>> hw/rtl/wtlo_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wtlo_front
// Accepts input words, drops unused actions and queues the rest.
// ---------------------------------------------------------------------------
module wtlo_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire wtlo_pkg::wtlo_cmd_t in_cmd,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output wtlo_pkg::wtlo_cmd_t     q_cmd
);
    import wtlo_pkg::*;

    localparam int DEPTH = 4;

    wtlo_cmd_t  mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 3'(DEPTH));
    assign push     = in_valid && in_ready && (in_cmd.action != ACT_NONE);
    assign pop      = q_valid && q_ready;
    assign q_valid  = (count_reg != 3'd0);
    assign q_cmd    = mem_reg[rd_ptr_reg];

    // store queued commands
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

endmodule : wtlo_front
`default_nettype wire

>>> hw/rtl/wtlo_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wtlo_div
// Sequential signed divide of a ramp difference by the ramp length,
// one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module wtlo_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [32:0] dividend,  // signed
    input  wire logic [15:0] divisor,
    output logic             busy,
    output logic [32:0]      quotient   // signed
);
    logic [32:0] num_reg;
    logic [32:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] den_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic [16:0] trial;

    assign trial    = {rem_reg[15:0], num_reg[32]} - {1'b0, den_reg};
    assign busy     = (cnt_reg != 6'd0);
    assign quotient = neg_reg ? (33'd0 - quo_reg) : quo_reg;

    // shift and subtract
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 6'd33;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[32];
            num_reg <= dividend[32] ? (33'd0 - dividend) : dividend;
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= divisor;
        end else if (busy) begin
            num_reg <= {num_reg[31:0], 1'b0};
            if (!trial[16]) begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[31:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[15:0], num_reg[32]};
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
        end
    end

endmodule : wtlo_div
`default_nettype wire

>>> hw/rtl/wtlo_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wtlo_back
// Executes queued commands: pixel writes, endpoint ramps and sample
// rendering through a sequencer.
// ---------------------------------------------------------------------------
module wtlo_back #(
    parameter int MAX_WIDTH  = wtlo_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wtlo_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wtlo_pkg::wtlo_cfg_t cfg,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire wtlo_pkg::wtlo_cmd_t q_cmd,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [15:0]              out_sample,
    output logic                     out_degen
);
    import wtlo_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int SW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_ADV, S_LERP, S_SCALE, S_IDX,
        S_RD0, S_RD1, S_RD2, S_RD3, S_ACC, S_QUOT, S_OUT
    } state_t;

    state_t      state_reg;
    logic [7:0]  pix_mem [2**AW];
    logic [31:0] sm_reg [4];
    logic [15:0] tg_reg [4];
    logic [31:0] st_reg [4];
    logic [15:0] rem_reg [4];
    logic [31:0] phase_reg;
    logic [63:0] tgt_new_reg;
    logic [1:0]  ci_reg;
    logic        dv_pend_reg;
    logic [48:0] px_reg, py_reg;
    logic [63:0] sx_reg, sy_reg;
    logic [XW-1:0] ix_reg, ix1_reg;
    logic [YW-1:0] iy_reg, iy1_reg;
    logic [16:0] fx_reg, fy_reg;
    logic [7:0]  rd_reg;
    logic [1:0]  rd_sel_reg;
    logic [41:0] acc_reg;
    logic [33:0] w_reg;
    logic [15:0] samp_reg;
    logic        degen_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;
    logic [SW-1:0] wcl;
    logic [HW-1:0] hcl;
    logic [15:0] tnew;
    logic        dv_start, dv_busy;
    logic [32:0] dv_q;
    logic [32:0] diff;
    logic [27:0] q28;
    logic [41:0] qmul;

    // clamp image size
    always_comb begin
        if (cfg.width == 9'd0) wcl = SW'(1);
        else if ({23'd0, cfg.width} > 32'(MAX_WIDTH)) wcl = SW'(MAX_WIDTH);
        else wcl = SW'(cfg.width);
        if (cfg.height == 9'd0) hcl = HW'(1);
        else if ({23'd0, cfg.height} > 32'(MAX_HEIGHT)) hcl = HW'(MAX_HEIGHT);
        else hcl = HW'(cfg.height);
    end

    assign tnew     = tgt_new_reg[16*ci_reg +: 16];
    assign diff     = {1'b0, tnew, 16'd0} - {1'b0, sm_reg[ci_reg]};
    assign dv_start = (state_reg == S_DIV) && !dv_pend_reg && (tnew != tg_reg[ci_reg])
                      && (cfg.ramp >= 16'd2);

    wtlo_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .dividend(diff),
        .divisor(cfg.ramp), .busy(dv_busy), .quotient(dv_q)
    );

    assign q_ready   = (state_reg == S_IDLE) && !out_valid;
    assign out_valid = (state_reg == S_OUT);
    assign out_sample = samp_reg;
    assign out_degen  = degen_reg;

    // pixel read address per neighbor
    always_comb begin
        case (rd_sel_reg)
            2'd0:    rd_addr = {iy_reg, ix_reg};
            2'd1:    rd_addr = {iy_reg, ix1_reg};
            2'd2:    rd_addr = {iy1_reg, ix_reg};
            default: rd_addr = {iy1_reg, ix1_reg};
        endcase
    end
    assign rd_en = (state_reg == S_RD0) || (state_reg == S_RD1) ||
                   (state_reg == S_RD2) || (state_reg == S_RD3);

    // pixel memory
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && q_cmd.action == ACT_PIXEL &&
            32'(q_cmd.col) < 32'(MAX_WIDTH) && 32'(q_cmd.row) < 32'(MAX_HEIGHT)) begin
            pix_mem[{YW'(q_cmd.row), XW'(q_cmd.col)}] <= q_cmd.bright;
        end
        if (rd_en) rd_reg <= pix_mem[rd_addr];
    end

    // divide by 255*65536 via reciprocal: q = ((((B+c)>>16)+128)*257)>>16, then fix
    assign q28  = acc_reg[41:16] + 28'd128;
    assign qmul = 42'(q28) * 42'd257;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= '0;
            for (int i = 0; i < 4; i++) begin
                tg_reg[i]  <= (i < 2) ? COORD_LOW_RESET : COORD_HIGH_RESET;
                sm_reg[i]  <= {((i < 2) ? COORD_LOW_RESET : COORD_HIGH_RESET), 16'd0};
                st_reg[i]  <= '0;
                rem_reg[i] <= '0;
            end
            ci_reg      <= '0;
            dv_pend_reg <= 1'b0;
            rd_sel_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        tgt_new_reg <= q_cmd.targets;
                        ci_reg      <= '0;
                        dv_pend_reg <= 1'b0;
                        if (q_cmd.action == ACT_LINE) state_reg <= S_DIV;
                        else if (q_cmd.action == ACT_SAMPLE) state_reg <= S_ADV;
                    end
                end
                // set targets one coordinate at a time
                S_DIV: begin
                    if (tnew == tg_reg[ci_reg]) begin
                        ci_reg <= ci_reg + 2'd1;
                        if (ci_reg == 2'd3) state_reg <= S_IDLE;
                    end else if (cfg.ramp == 16'd0) begin
                        tg_reg[ci_reg]  <= tnew;
                        sm_reg[ci_reg]  <= {tnew, 16'd0};
                        rem_reg[ci_reg] <= '0;
                        st_reg[ci_reg]  <= '0;
                        ci_reg <= ci_reg + 2'd1;
                        if (ci_reg == 2'd3) state_reg <= S_IDLE;
                    end else if (cfg.ramp == 16'd1) begin
                        tg_reg[ci_reg]  <= tnew;
                        rem_reg[ci_reg] <= cfg.ramp;
                        st_reg[ci_reg]  <= '0;
                        ci_reg <= ci_reg + 2'd1;
                        if (ci_reg == 2'd3) state_reg <= S_IDLE;
                    end else if (!dv_pend_reg) begin
                        dv_pend_reg <= 1'b1;
                    end else if (!dv_busy) begin
                        tg_reg[ci_reg]  <= tnew;
                        rem_reg[ci_reg] <= cfg.ramp;
                        st_reg[ci_reg]  <= dv_q[31:0];
                        dv_pend_reg <= 1'b0;
                        ci_reg <= ci_reg + 2'd1;
                        if (ci_reg == 2'd3) state_reg <= S_IDLE;
                    end
                end
                // advance all smoothers
                S_ADV: begin
                    for (int i = 0; i < 4; i++) begin
                        if (rem_reg[i] == 16'd0 || rem_reg[i] == 16'd1) begin
                            sm_reg[i] <= {tg_reg[i], 16'd0};
                        end else begin
                            sm_reg[i] <= sm_reg[i] + st_reg[i];
                        end
                        if (rem_reg[i] != 16'd0) rem_reg[i] <= rem_reg[i] - 16'd1;
                    end
                    state_reg <= S_LERP;
                end
                S_LERP: begin
                    if (sm_reg[0] == sm_reg[2] && sm_reg[1] == sm_reg[3]) begin
                        samp_reg  <= '0;
                        degen_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        degen_reg <= 1'b0;
                        px_reg <= 49'(sm_reg[0][31:16])
                                    * (49'h1_0000_0000 - 49'(phase_reg))
                                + 49'(sm_reg[2][31:16]) * 49'(phase_reg);
                        py_reg <= 49'(sm_reg[1][31:16])
                                    * (49'h1_0000_0000 - 49'(phase_reg))
                                + 49'(sm_reg[3][31:16]) * 49'(phase_reg);
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    sx_reg <= 64'(px_reg) * 64'(wcl - SW'(1));
                    sy_reg <= 64'(py_reg) * 64'(hcl - HW'(1));
                    state_reg <= S_IDX;
                end
                S_IDX: begin
                    if (sx_reg[63:48] > 16'(wcl - SW'(1))) ix_reg <= XW'(wcl - SW'(1));
                    else ix_reg <= sx_reg[48 +: XW];
                    if (sy_reg[63:48] > 16'(hcl - HW'(1))) iy_reg <= YW'(hcl - HW'(1));
                    else iy_reg <= sy_reg[48 +: YW];
                    if (sx_reg[63:48] + 16'd1 > 16'(wcl - SW'(1))) ix1_reg <= XW'(wcl - SW'(1));
                    else ix1_reg <= XW'(sx_reg[63:48] + 16'd1);
                    if (sy_reg[63:48] + 16'd1 > 16'(hcl - HW'(1))) iy1_reg <= YW'(hcl - HW'(1));
                    else iy1_reg <= YW'(sy_reg[63:48] + 16'd1);
                    fx_reg <= {1'b0, sx_reg[47:32]};
                    fy_reg <= {1'b0, sy_reg[47:32]};
                    acc_reg    <= 42'd8355840;
                    rd_sel_reg <= 2'd0;
                    state_reg  <= S_RD0;
                end
                // weight for next neighbor while reading
                S_RD0: begin
                    w_reg <= (34'h1_0000 - 34'(fx_reg)) * (34'h1_0000 - 34'(fy_reg));
                    rd_sel_reg <= 2'd1;
                    state_reg <= S_RD1;
                end
                S_RD1: begin
                    acc_reg <= acc_reg + 42'(rd_reg) * 42'(w_reg);
                    w_reg <= 34'(fx_reg) * (34'h1_0000 - 34'(fy_reg));
                    rd_sel_reg <= 2'd2;
                    state_reg <= S_RD2;
                end
                S_RD2: begin
                    acc_reg <= acc_reg + 42'(rd_reg) * 42'(w_reg);
                    w_reg <= (34'h1_0000 - 34'(fx_reg)) * 34'(fy_reg);
                    rd_sel_reg <= 2'd3;
                    state_reg <= S_RD3;
                end
                S_RD3: begin
                    acc_reg <= acc_reg + 42'(rd_reg) * 42'(w_reg);
                    w_reg <= 34'(fx_reg) * 34'(fy_reg);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= acc_reg + 42'(rd_reg) * 42'(w_reg);
                    state_reg <= S_QUOT;
                end
                // floor(acc / (255*65536)) by reciprocal estimate and fix
                S_QUOT: begin
                    logic [41:0] est;
                    logic [41:0] prod;
                    est  = qmul >> 16;
                    prod = est * 42'd16711680;
                    if (prod > acc_reg) est = est - 42'd1;
                    else if (acc_reg - prod >= 42'd16711680) est = est + 42'd1;
                    if (est >= 42'd65535) samp_reg <= 16'h7FFF;
                    else samp_reg <= 16'(est) - 16'h8000;
                    phase_reg <= phase_reg + cfg.phase_inc;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule : wtlo_back
`default_nettype wire

>>> hw/rtl/wave_terrain_line_oscillator.sv
`default_nettype none
// A sample word passes the sequencer states ADV, LERP, SCALE, IDX, RD0 to
// RD3, ACC and QUOT before m_tvalid rises (a degenerate line goes from LERP
// to the output); a line word runs the sequential 33-step divider once per
// changed coordinate at ramp >= 2. The back end takes one item at a time, set
// by its sequencer; a 4-entry queue lets the front keep accepting meanwhile.
// Reset: synchronous active-low aresetn restores registers and coordinates;
// pixel contents are undefined until written.
// ---------------------------------------------------------------------------
// wave_terrain_line_oscillator
// Wave-terrain oscillator reading a brightness image along a smoothed line.
// ---------------------------------------------------------------------------
module wave_terrain_line_oscillator #(
    parameter int MAX_WIDTH  = wtlo_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wtlo_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_wr_index,
    input  wire logic [31:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pixel_col, pixel_row, pixel_brightness, start_x, start_y, end_x, end_y
    input  wire logic [87:0]  s_tdata,
    // action
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // sample_value
    output logic [15:0]       m_tdata,
    // line_degenerate
    output logic              m_tuser
);
    import wtlo_pkg::*;

    wtlo_cfg_t  cfg_reg;
    wtlo_cmd_t  in_cmd, q_cmd;
    logic       q_valid, q_ready;
    logic [15:0] sample;
    logic        degen;

    // hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_inc <= PHASE_INC_RESET;
            cfg_reg.width     <= SIZE_RESET;
            cfg_reg.height    <= SIZE_RESET;
            cfg_reg.ramp      <= RAMP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_PHASE_INC: cfg_reg.phase_inc <= cfg_wr_data;
                REG_WIDTH:     cfg_reg.width     <= cfg_wr_data[8:0];
                REG_HEIGHT:    cfg_reg.height    <= cfg_wr_data[8:0];
                REG_RAMP:      cfg_reg.ramp      <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign in_cmd.action  = s_tuser;
    assign in_cmd.col     = s_tdata[7:0];
    assign in_cmd.row     = s_tdata[15:8];
    assign in_cmd.bright  = s_tdata[23:16];
    assign in_cmd.targets = s_tdata[87:24];

    wtlo_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    wtlo_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_sample(sample), .out_degen(degen)
    );

    assign m_tdata = sample;
    assign m_tuser = degen;

endmodule : wave_terrain_line_oscillator
`default_nettype wire

>>> tb/tb_wave_terrain_line_oscillator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_wave_terrain_line_oscillator
// Self-checking bench for the wave-terrain line oscillator. Items are built
// phase by phase and run through a bit-exact predictor as they are built.
// Any pixel a sample would read is written first. A bursty driver and a
// stalling monitor move the words, and each result word is compared with
// the oldest predicted sample.
// ---------------------------------------------------------------------------
module tb_wave_terrain_line_oscillator;
    import wtlo_pkg::*;

    localparam int  NUM_ITEMS   = 1150;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 1000;

    typedef struct {
        logic [15:0] sample;
        logic        degen;
    } sample_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [1:0]   cfg_wr_index;
    logic [31:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;
    logic         m_tuser;

    wave_terrain_line_oscillator u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    // words waiting for the driver (tdata above tuser), samples for the monitor
    logic [89:0] word_q[$];
    sample_t     sample_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          counted = 0;

    // oscillator state mirrored by the predictor
    logic [7:0]  img[65536];
    bit          img_set[65536];
    logic [31:0] phase;
    logic [31:0] coord[4];
    logic [15:0] target[4];
    longint      step[4];
    logic [15:0] left[4];
    logic [31:0] r_inc;
    logic [8:0]  r_width;
    logic [8:0]  r_height;
    logic [15:0] r_ramp;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic logic [89:0] pack_word(logic [1:0] act, logic [7:0] col,
            logic [7:0] row, logic [7:0] br, logic [15:0] sx, logic [15:0] sy,
            logic [15:0] ex, logic [15:0] ey);
        return {ey, ex, sy, sx, br, row, col, act};
    endfunction

    // queue one word and count it
    task automatic push_word(logic [89:0] w);
        word_q.push_back(w);
        counted++;
    endtask

    task automatic retarget(int i, logic [15:0] t);
        longint diff;
        if (t == target[i]) return;
        target[i] = t;
        if (r_ramp == 16'd0) begin
            coord[i] = {t, 16'd0};
            left[i]  = '0;
            step[i]  = 0;
            return;
        end
        left[i] = r_ramp;
        if (r_ramp >= 16'd2) begin
            diff    = longint'({t, 16'd0}) - longint'(coord[i]);
            step[i] = diff / longint'(r_ramp);
        end else begin
            step[i] = 0;
        end
    endtask

    task automatic queue_pixel(logic [7:0] col, logic [7:0] row, logic [7:0] br);
        img[{row, col}]     = br;
        img_set[{row, col}] = 1'b1;
        push_word(pack_word(ACT_PIXEL, col, row, br, '0, '0, '0, '0));
    endtask

    task automatic queue_line(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
            logic [15:0] ey);
        retarget(0, sx);
        retarget(1, sy);
        retarget(2, ex);
        retarget(3, ey);
        push_word(pack_word(ACT_LINE, '0, '0, '0, sx, sy, ex, ey));
    endtask

    // advance the glides, predict one sample and, unless the line is degenerate, advance the phase
    task automatic queue_sample();
        longint unsigned inv, px, py, sx, sy, fx, fy, b, q, w, h, ix, iy, ix1, iy1;
        longint unsigned pix[4], wt[4];
        longint v;
        int idx[4];
        sample_t e;
        for (int i = 0; i < 4; i++) begin
            if (left[i] == 16'd0) begin
                coord[i] = {target[i], 16'd0};
            end else begin
                left[i]--;
                if (left[i] != 16'd0) coord[i] = 32'(longint'(coord[i]) + step[i]);
                else coord[i] = {target[i], 16'd0};
            end
        end
        if (coord[0] == coord[2] && coord[1] == coord[3]) begin
            e.sample = '0;
            e.degen  = 1'b1;
            sample_q.push_back(e);
            push_word(pack_word(ACT_SAMPLE, '0, '0, '0, '0, '0, '0, '0));
            return;
        end
        inv = 64'h1_0000_0000 - phase;
        px  = (coord[0] >> 16) * inv + (coord[2] >> 16) * phase;
        py  = (coord[1] >> 16) * inv + (coord[3] >> 16) * phase;
        w   = (r_width == 0) ? 1 : (r_width > 256) ? 256 : r_width;
        h   = (r_height == 0) ? 1 : (r_height > 256) ? 256 : r_height;
        sx  = px * (w - 1);
        sy  = py * (h - 1);
        ix  = sx >> 48;
        iy  = sy >> 48;
        fx  = (sx >> 32) & 16'hFFFF;
        fy  = (sy >> 32) & 16'hFFFF;
        if (ix > w - 1) ix = w - 1;
        if (iy > h - 1) iy = h - 1;
        ix1 = (ix + 1 > w - 1) ? w - 1 : ix + 1;
        iy1 = (iy + 1 > h - 1) ? h - 1 : iy + 1;
        idx[0] = int'(iy * 256 + ix);
        idx[1] = int'(iy * 256 + ix1);
        idx[2] = int'(iy1 * 256 + ix);
        idx[3] = int'(iy1 * 256 + ix1);
        // never let the block read a pixel that was not written
        for (int i = 0; i < 4; i++) begin
            if (!img_set[idx[i]])
                queue_pixel(idx[i][7:0], idx[i][15:8], 8'($urandom));
            pix[i] = img[idx[i]];
        end
        wt[0] = (65536 - fx) * (65536 - fy);
        wt[1] = fx * (65536 - fy);
        wt[2] = (65536 - fx) * fy;
        wt[3] = fx * fy;
        b = 0;
        for (int i = 0; i < 4; i++) b += pix[i] * wt[i];
        q = (b + 255 * 32768) / (255 * 65536);
        v = longint'(q) - 32768;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        e.sample = 16'(v);
        e.degen  = 1'b0;
        sample_q.push_back(e);
        push_word(pack_word(ACT_SAMPLE, '0, '0, '0, '0, '0, '0, '0));
        phase = phase + r_inc;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            REG_PHASE_INC: r_inc = data;
            REG_WIDTH:     r_width = data[8:0];
            REG_HEIGHT:    r_height = data[8:0];
            REG_RAMP:      r_ramp = data[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // hold until every word is taken and every sample has come back
    task automatic drain();
        while (word_q.size() != 0 || s_tvalid || sample_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mixed traffic, mostly samples with occasional retargets and writes
    task automatic random_traffic(int n);
        logic [15:0] x, y;
        int k;
        int stop;
        stop = counted + n;
        while (counted < stop) begin
            k = $urandom_range(0, 99);
            if (k < 10) begin
                queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            end else if (k < 16) begin
                queue_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end else if (k < 19) begin
                // collapse the line to one point
                x = rand_coord();
                y = rand_coord();
                queue_line(x, y, x, y);
            end else if (k < 20) begin
                queue_line(target[0], target[1], target[2], target[3]);
            end else if (k < 22) begin
                push_word(pack_word(ACT_NONE, 8'($urandom), 8'($urandom),
                    8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom)));
            end else begin
                queue_sample();
            end
        end
    endtask

    task automatic pick_config();
        logic [31:0] inc;
        case ($urandom_range(0, 5))
            0:       inc = 32'd0;
            1:       inc = 32'h8000_0000;
            2:       inc = 32'hFFFF_FFFF;
            default: inc = $urandom;
        endcase
        write_reg(REG_PHASE_INC, inc);
        write_reg(REG_WIDTH, $urandom_range(0, 5) == 0 ? $urandom_range(0, 511)
                                                         : $urandom_range(1, 256));
        write_reg(REG_HEIGHT, $urandom_range(0, 5) == 0 ? $urandom_range(0, 511)
                                                          : $urandom_range(1, 256));
        case ($urandom_range(0, 6))
            0:       write_reg(REG_RAMP, 32'd0);
            1:       write_reg(REG_RAMP, 32'd1);
            2:       write_reg(REG_RAMP, 32'd65535);
            default: write_reg(REG_RAMP, $urandom_range(2, 24));
        endcase
    endtask

    // stimulus
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_PHASE_INC;
        cfg_wr_data  = '0;
        phase        = '0;
        r_inc        = PHASE_INC_RESET;
        r_width      = SIZE_RESET;
        r_height     = SIZE_RESET;
        r_ramp       = RAMP_RESET;
        for (int i = 0; i < 4; i++) begin
            target[i] = (i < 2) ? COORD_LOW_RESET : COORD_HIGH_RESET;
            coord[i]  = {target[i], 16'd0};
            step[i]   = 0;
            left[i]   = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners, full and dark pixels, extremes, unused action
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_sample();
        queue_sample();
        push_word(pack_word(ACT_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 16'hFFFF));
        queue_line(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        queue_line(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        queue_sample();
        queue_sample();
        drain();
        write_reg(REG_RAMP, 32'd0);
        write_reg(REG_PHASE_INC, 32'h8000_0000);
        queue_line(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_sample();
        queue_sample();
        queue_line(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        queue_pixel(8'd255, 8'd0, 8'd255);
        queue_pixel(8'd0, 8'd255, 8'd255);
        queue_sample();
        queue_sample();
        queue_sample();
        drain();
        write_reg(REG_RAMP, 32'd1);
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_HEIGHT, 32'd511);
        queue_line(16'd100, 16'd0, 16'd200, 16'hFFFF);
        queue_sample();
        queue_sample();
        queue_sample();
        drain();
        write_reg(REG_WIDTH, 32'd2);
        write_reg(REG_HEIGHT, 32'd1);

        // random phases, each under its own setting
        while (counted < NUM_ITEMS) begin
            random_traffic($urandom_range(120, 200));
            drain();
            pick_config();
        end
        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    logic [89:0] next_word;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else if (s_tvalid && !s_tready) begin
            // hold the word until it is taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (word_q.size() != 0) begin
            next_word = word_q.pop_front();
            s_tuser  <= next_word[1:0];
            s_tdata  <= next_word[89:2];
            s_tvalid <= 1'b1;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern that switches between modes
    int stall_mode = 0;
    int mode_left  = 0;
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // check each result word against the oldest predicted sample
    always @(posedge aclk) begin
        sample_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                errors++;
                $error("unexpected result word %h", m_tdata);
            end else begin
                e = sample_q.pop_front();
                if (m_tdata !== e.sample) begin
                    errors++;
                    $error("sample_value expected %0d got %0d", $signed(e.sample),
                        $signed(m_tdata));
                end
                if (m_tuser !== e.degen) begin
                    errors++;
                    $error("line_degenerate expected %0b got %0b", e.degen, m_tuser);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
